// ----- hw/rtl/sas_pkg.sv -----
// Shared types, opcodes, state codes and the exp2 fraction table for the
// softmax action sampler. Depends on nothing; sas_dp, sas_ctrl and the top level import it.
package sas_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_PROB   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] REG_TEMPERATURE = 2'd0;
    localparam logic [1:0] REG_NUM_ACTIONS = 2'd1;

    // log2(e) in Q1.12.
    localparam logic [12:0] LOG2E_Q12 = 13'd5909;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         state_index;
        logic [3:0]         action_index;
        logic signed [15:0] q_value;
        logic [15:0]        random_draw;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  action;
        logic [15:0] probability;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISP, ST_MAX_A, ST_MAX_B, ST_W_A, ST_W_B, ST_W_DIV, ST_W_WR,
        ST_THR, ST_S_A, ST_S_B, ST_P_SET, ST_P_RD, ST_P_DS, ST_P_DIV, ST_FIN
    } t_state;

    typedef enum logic [1:0] {OS_SAMPLE, OS_USAMPLE, OS_PROB, OS_ZERO} t_osel;
    typedef enum logic [1:0] {DS_WEIGHT, DS_PROB, DS_UNIF} t_dsel;

    typedef struct packed {
        logic  load;
        logic  idx_clr;
        logic  idx_inc;
        logic  idx_act;
        logic  max_acc;
        logic  div_start;
        t_dsel div_sel;
        logic  w_wr;
        logic  thr_load;
        logic  run_acc;
        logic  out_load;
        t_osel out_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       tau_zero;
        logic       act_ok;
        logic       idx_last;
        logic       div_busy;
        logic       run_gt;
    } t_stat;

    // round(65536 * 2^(-f/16))
    function automatic logic [16:0] frac_pow2(input logic [3:0] f);
        logic [16:0] v;
        unique case (f)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd62757;
            4'd2:  v = 17'd60096;
            4'd3:  v = 17'd57548;
            4'd4:  v = 17'd55109;
            4'd5:  v = 17'd52773;
            4'd6:  v = 17'd50535;
            4'd7:  v = 17'd48393;
            4'd8:  v = 17'd46341;
            4'd9:  v = 17'd44376;
            4'd10: v = 17'd42495;
            4'd11: v = 17'd40693;
            4'd12: v = 17'd38968;
            4'd13: v = 17'd37316;
            4'd14: v = 17'd35734;
            4'd15: v = 17'd34219;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/sas_div.sv -----
// Restoring divider, one quotient bit per cycle, for the sampler datapath.
// Depends on nothing outside this file.
module sas_div #(
    parameter int NUMW = 33,
    parameter int DENW = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_busy,
    output logic [NUMW-1:0] o_quo
);
    localparam int CW = $clog2(NUMW + 1);

    logic [CW-1:0]   r_cnt, n_cnt;
    logic [DENW-1:0] r_rem, n_rem, r_den;
    logic [NUMW-1:0] r_quo, n_quo;
    logic [DENW:0]   trial;

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        trial = {r_rem, r_quo[NUMW-1]};
        if (i_start) begin
            n_cnt = CW'(NUMW);
            n_rem = '0;
            n_quo = i_num;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (trial >= {1'b0, r_den}) begin
                n_rem = DENW'(trial - {1'b0, r_den});
                n_quo = {r_quo[NUMW-2:0], 1'b1};
            end else begin
                n_rem = DENW'(trial);
                n_quo = {r_quo[NUMW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
endmodule

// ----- hw/rtl/sas_dp.sv -----
// Datapath of the softmax action sampler: Q table, weight store, max,
// total, threshold and result registers. Depends on sas_pkg and sas_div.
module sas_dp #(
    parameter int STATES  = 256,
    parameter int ACTIONS = 16,
    parameter int Q_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sas_pkg::t_in_item i_in,
    input  logic [15:0]       i_tau,
    input  logic [4:0]        i_num,
    input  sas_pkg::t_cmd     i_cmd,
    output sas_pkg::t_stat    o_stat,
    output sas_pkg::t_out_item o_out
);
    import sas_pkg::*;

    localparam int AW   = $clog2(STATES * ACTIONS);
    localparam int IW   = $clog2(ACTIONS);
    localparam int NW   = $clog2(ACTIONS + 1);
    localparam int DW   = Q_WIDTH + 1;
    localparam int TW   = 17 + IW;
    localparam int NUMW = (DW + 13 > 33) ? DW + 13 : 33;
    localparam int DENW = (TW > 24) ? TW : 24;

    logic signed [Q_WIDTH-1:0] q_mem [STATES * ACTIONS];
    logic [16:0]               w_mem [ACTIONS];

    logic [1:0]                r_op;
    logic [3:0]                r_act;
    logic [15:0]               r_draw;
    logic [AW-1:0]             r_base;
    logic [NW-1:0]             r_n;
    logic [IW-1:0]             r_idx;
    logic signed [Q_WIDTH-1:0] r_q_rd, r_qmax;
    logic [16:0]               r_w_rd;
    logic [TW-1:0]             r_total, r_run, r_thr;
    t_out_item                 r_out;

    logic [7:0]                row;
    logic [AW-1:0]             base_now;
    logic [NW-1:0]             n_now;
    logic signed [31:0]        q_ext;
    logic [DW-1:0]             diff;
    logic                      div_busy;
    logic [NUMW-1:0]           quo, div_num;
    logic [DENW-1:0]           div_den;
    logic [16:0]               w_new;
    logic [TW-1:0]             run_nx;
    logic [TW+15:0]            thr_prod;
    logic [31:0]               u_prod;
    logic [15:0]               p_sat;

    // Row number modulo STATES by shifted compare and subtract.
    function automatic logic [7:0] row_of(input logic [7:0] st);
        logic [7:0] r;
        r = st;
        if (STATES < 256) begin
            for (int k = 7; k >= 0; k--) begin
                if ((32'(STATES) << k) <= 32'(r)) begin
                    r = r - 8'(32'(STATES) << k);
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        row      = row_of(i_in.state_index);
        base_now = AW'(32'(row) * ACTIONS);
        if (i_num == 5'd0) begin
            n_now = NW'(1);
        end else if (32'(i_num) > ACTIONS) begin
            n_now = NW'(ACTIONS);
        end else begin
            n_now = NW'(i_num);
        end
        q_ext  = 32'(i_in.q_value);
        diff   = DW'(r_qmax) - DW'(r_q_rd);
        run_nx = r_run + TW'(r_w_rd);
        thr_prod = (TW+16)'(r_total) * (TW+16)'(r_draw);
        u_prod = 32'(r_draw) * 32'(r_n);
        p_sat  = (quo > NUMW'(65535)) ? 16'hFFFF : quo[15:0];
        if (quo[NUMW-1:4] >= (NUMW-4)'(17)) begin
            w_new = '0;
        end else begin
            w_new = frac_pow2(quo[3:0]) >> quo[8:4];
        end
        unique case (i_cmd.div_sel)
            DS_WEIGHT: begin
                div_num = NUMW'(NUMW'(diff) * NUMW'(LOG2E_Q12));
                div_den = DENW'({i_tau, 8'h00});
            end
            DS_PROB: begin
                div_num = NUMW'({r_w_rd, 16'h0000});
                div_den = DENW'(r_total);
            end
            DS_UNIF: begin
                div_num = NUMW'(32'h0001_0000);
                div_den = DENW'(r_n);
            end
            default: begin
                div_num = '0;
                div_den = '1;
            end
        endcase
    end

    sas_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_in.opcode == OP_WRITE && 32'(i_in.action_index) < ACTIONS) begin
            q_mem[AW'(base_now + AW'(i_in.action_index))] <= q_ext[Q_WIDTH-1:0];
        end
        r_q_rd <= q_mem[AW'(r_base + AW'(r_idx))];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_wr) begin
            w_mem[r_idx] <= w_new;
        end
        r_w_rd <= w_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in.opcode;
            r_act  <= i_in.action_index;
            r_draw <= i_in.random_draw;
            r_base <= base_now;
            r_n    <= n_now;
        end
        if (i_cmd.load || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_act) begin
            r_idx <= IW'(r_act);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.max_acc && (r_idx == '0 || r_q_rd > r_qmax)) begin
            r_qmax <= r_q_rd;
        end
        if (i_cmd.load) begin
            r_total <= '0;
        end else if (i_cmd.w_wr) begin
            r_total <= r_total + TW'(w_new);
        end
        if (i_cmd.load) begin
            r_run <= '0;
        end else if (i_cmd.run_acc) begin
            r_run <= run_nx;
        end
        if (i_cmd.thr_load) begin
            r_thr <= thr_prod[TW+15:16];
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                OS_SAMPLE:  r_out <= '{result_kind: 1'b0, action: 4'(r_idx), probability: 16'd0};
                OS_USAMPLE: r_out <= '{result_kind: 1'b0, action: u_prod[19:16],
                                       probability: 16'd0};
                OS_PROB:    r_out <= '{result_kind: 1'b1, action: r_act, probability: p_sat};
                OS_ZERO:    r_out <= '{result_kind: 1'b1, action: r_act, probability: 16'd0};
                default:    r_out <= r_out;
            endcase
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.tau_zero = (i_tau == 16'd0);
    assign o_stat.act_ok   = (NW + 4)'(r_act) < (NW + 4)'(r_n);
    assign o_stat.idx_last = ((NW + 1)'(r_idx) == (NW + 1)'(r_n - 1'b1));
    assign o_stat.div_busy = div_busy;
    assign o_stat.run_gt   = (run_nx > r_thr);
    assign o_out           = r_out;
endmodule

// ----- hw/rtl/sas_ctrl.sv -----
// Sequencer of the softmax action sampler: walks the passes over a Q row and
// owns the channel handshakes. Depends on sas_pkg.
module sas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  sas_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output sas_pkg::t_cmd  o_cmd
);
    import sas_pkg::*;

    t_state r_state, n_state;
    t_osel  r_osel, n_osel;
    logic   r_ovalid, n_ovalid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_osel   <= OS_ZERO;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_osel   <= n_osel;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_osel   = r_osel;
        o_cmd    = '0;
        out_free = !r_ovalid || !i_out_stall;
        n_ovalid = r_ovalid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                priority if (i_stat.op == OP_SAMPLE && i_stat.tau_zero) begin
                    n_osel  = OS_USAMPLE;
                    n_state = ST_FIN;
                end else if (i_stat.op == OP_SAMPLE) begin
                    n_state = ST_MAX_A;
                end else if (i_stat.op == OP_PROB && !i_stat.act_ok) begin
                    n_osel  = OS_ZERO;
                    n_state = ST_FIN;
                end else if (i_stat.op == OP_PROB && i_stat.tau_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_UNIF;
                    n_state         = ST_P_DIV;
                end else if (i_stat.op == OP_PROB) begin
                    n_state = ST_MAX_A;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAX_A: n_state = ST_MAX_B;
            ST_MAX_B: begin
                o_cmd.max_acc = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_W_A;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_MAX_A;
                end
            end
            ST_W_A: n_state = ST_W_B;
            ST_W_B: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_WEIGHT;
                n_state         = ST_W_DIV;
            end
            ST_W_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_W_WR;
                end
            end
            ST_W_WR: begin
                o_cmd.w_wr = 1'b1;
                if (!i_stat.idx_last) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_W_A;
                end else if (i_stat.op == OP_SAMPLE) begin
                    n_state = ST_THR;
                end else begin
                    n_state = ST_P_SET;
                end
            end
            ST_THR: begin
                o_cmd.thr_load = 1'b1;
                o_cmd.idx_clr  = 1'b1;
                n_state        = ST_S_A;
            end
            ST_S_A: n_state = ST_S_B;
            ST_S_B: begin
                o_cmd.run_acc = 1'b1;
                if (i_stat.run_gt || i_stat.idx_last) begin
                    n_osel  = OS_SAMPLE;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_S_A;
                end
            end
            ST_P_SET: begin
                o_cmd.idx_act = 1'b1;
                n_state       = ST_P_RD;
            end
            ST_P_RD: n_state = ST_P_DS;
            ST_P_DS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_PROB;
                n_state         = ST_P_DIV;
            end
            ST_P_DIV: begin
                if (!i_stat.div_busy) begin
                    n_osel  = OS_PROB;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = r_osel;
                    n_ovalid       = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
endmodule

// ----- hw/rtl/softmax_action_sampler.sv -----
// Top level of the softmax action sampler: configuration registers, the
// sequencer and the datapath. Depends on sas_pkg, sas_ctrl and sas_dp.
//
//  Channel | Direction | Handshake                 | Content
//  in      | input     | i_in_valid / o_in_stall   | t_in_item: opcode, state, action, q, draw
//  out     | output    | o_out_valid / i_out_stall | t_out_item: kind, action, probability
//  cfg     | input     | i_cfg_valid / o_cfg_ready | register index and write data
//
// The block works on one item at a time. A write or an ignored opcode only
// passes through dispatch; a uniform sample needs no divide and a uniform
// query one divide in the bit-serial divider, whose quotient is NUMW bits
// wide (33 at the default Q width). A query for action n or above gives
// zero at once. A softmax sample over n actions makes one pass for the row
// maximum, one divide per weight, then the selection pass. A softmax query
// makes the same first two passes, then one divide giving the probability.
// Reset is synchronous and active low; the Q table is not cleared and holds
// nothing useful until written. A finished result waits in the output
// register while the next item is accepted; only loading a new result waits
// for the old one to be taken.
module softmax_action_sampler #(
    parameter int STATES  = 256,
    parameter int ACTIONS = 16,
    parameter int Q_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sas_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sas_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import sas_pkg::*;

    logic [15:0] r_tau;
    logic [4:0]  r_num;
    t_cmd        cmd;
    t_stat       stat;

    // Config is always accepted; the user keeps the block idle when it is written; unchecked.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau <= 16'd256;
            r_num <= 5'd16;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TEMPERATURE) begin
                r_tau <= i_cfg_data;
            end else if (i_cfg_index == REG_NUM_ACTIONS) begin
                r_num <= i_cfg_data[4:0];
            end
        end
    end

    sas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    sas_dp #(.STATES(STATES), .ACTIONS(ACTIONS), .Q_WIDTH(Q_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_tau   (r_tau),
        .i_num   (r_num),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    // The divider is never restarted while it is still working.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

    // An item is only taken once the previous one has left the divider.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !stat.div_busy)
        else $error("item accepted during a division");
`endif
endmodule
